FILE: rtl/motor_command_frame_parser_macros.svh
// Assertion macros for the motor command frame parser RTL.
// Expects clk_i and rst_ni in the scope of the including module.
`ifndef MOTOR_COMMAND_FRAME_PARSER_MACROS_SVH
`define MOTOR_COMMAND_FRAME_PARSER_MACROS_SVH

// same-cycle implication
`define MCFP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mcfp assertion failed");

// next-cycle implication
`define MCFP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mcfp assertion failed");

`endif

FILE: rtl/mcfp_pkg.sv
// Shared types and constants for the motor command frame parser.
// No dependencies.
`default_nettype none

package mcfp_pkg;

  localparam logic [7:0] HdrByte  = 8'h23;
  localparam logic [7:0] TailByte = 8'h21;
  localparam logic [7:0] AtByte   = 8'h40;
  localparam int unsigned DataLen = 9;
  localparam int unsigned RampBit = 0;

  typedef logic signed [7:0] sbyte_t;

  typedef struct packed {
    sbyte_t [3:0] speed;
    sbyte_t [3:0] angle_vel;
    logic         ramp;
  } held_t;

  typedef struct packed {
    logic  done;
    held_t held;
  } parse_evt_t;

endpackage

`default_nettype wire

FILE: rtl/mcfp_frame_fsm.sv
// Frame parser: header/data/tail state machine, data byte store, held values.
// Depends on mcfp_pkg.
`default_nettype none

module mcfp_frame_fsm (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic [7:0]         byte_i,
  output mcfp_pkg::parse_evt_t    evt_o
);
  import mcfp_pkg::*;

  localparam logic [1:0] PhHead = 2'd0;
  localparam logic [1:0] PhData = 2'd1;
  localparam logic [1:0] PhTail = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic [3:0] pos_q, pos_d;
  logic [DataLen-1:0][7:0] frame_q;
  held_t held_q, held_d;
  logic  wr_en;
  logic  take;

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    wr_en   = 1'b0;
    take    = 1'b0;
    unique case (phase_q)
      PhHead: begin
        if (byte_i == HdrByte) begin
          pos_d   = 4'd1;
          phase_d = PhData;
        end
      end
      PhData: begin
        if (pos_q >= 4'd1 && pos_q <= 4'(DataLen)) begin
          wr_en = 1'b1;
          pos_d = pos_q + 4'd1;
          if (pos_d > 4'(DataLen)) begin
            phase_d = PhTail;
          end
        end else begin
          phase_d = PhTail;
        end
      end
      PhTail: begin
        take    = (byte_i == TailByte);
        phase_d = PhHead;
      end
      default: begin
        phase_d = PhHead;
      end
    endcase
  end

  always_comb begin
    held_d = held_q;
    if (take) begin
      for (int i = 0; i < 4; i++) begin
        held_d.speed[i]     = sbyte_t'(frame_q[i]);
        held_d.angle_vel[i] = sbyte_t'(frame_q[5 + i]);
      end
      held_d.ramp = frame_q[4][RampBit];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHead;
      pos_q   <= 4'd0;
      held_q  <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      held_q  <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DataLen; i++) begin
      if (en_i && wr_en && pos_q == 4'(i + 1)) begin
        frame_q[i] <= byte_i;
      end
    end
  end

  assign evt_o.done = take;
  assign evt_o.held = held_d;

endmodule

`default_nettype wire

FILE: rtl/mcfp_seq_detect.sv
// Detector for the "!@!" encoder reset sequence over a three-byte history.
// Depends on mcfp_pkg.
`default_nettype none

module mcfp_seq_detect (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire logic [7:0] byte_i,
  output logic            hit_o
);
  import mcfp_pkg::*;

  logic [2:0][7:0] hist_q, hist_w;
  logic [1:0]      slot_q, slot_w, slot_nx, slot_mid;

  always_comb begin
    slot_w          = (slot_q > 2'd2) ? 2'd0 : slot_q;
    hist_w          = hist_q;
    hist_w[slot_w]  = byte_i;
    slot_nx         = (slot_w == 2'd2) ? 2'd0 : slot_w + 2'd1;
    slot_mid        = (slot_nx == 2'd2) ? 2'd0 : slot_nx + 2'd1;
    hit_o = (hist_w[slot_nx] == TailByte) && (hist_w[slot_mid] == AtByte) &&
            (hist_w[slot_w] == TailByte);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
      slot_q <= 2'd0;
    end else if (en_i) begin
      if (hit_o) begin
        hist_q <= '0;
        slot_q <= 2'd0;
      end else begin
        hist_q <= hist_w;
        slot_q <= slot_nx;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/motor_command_frame_parser.sv
// A byte's result passes through the input register and then the result register.
// Throughput: one byte per cycle while the result register is not stalled; the frame state
// machine and sequence detector each update as the byte leaves the input register.
// Reset: asynchronous, active low; parser waits for a header, history and held values clear.
// Depends on mcfp_pkg, mcfp_frame_fsm, mcfp_seq_detect and the assertion macro header.
`default_nettype none

module motor_command_frame_parser (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [7:0]          rx_byte_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     frame_done_o,
  output logic                     encoder_reset_o,
  output mcfp_pkg::sbyte_t         speed_a_o,
  output mcfp_pkg::sbyte_t         speed_b_o,
  output mcfp_pkg::sbyte_t         speed_c_o,
  output mcfp_pkg::sbyte_t         speed_d_o,
  output mcfp_pkg::sbyte_t         angle_vel_a_o,
  output mcfp_pkg::sbyte_t         angle_vel_b_o,
  output mcfp_pkg::sbyte_t         angle_vel_c_o,
  output mcfp_pkg::sbyte_t         angle_vel_d_o,
  output logic                     ramp_enable_o
);
  import mcfp_pkg::*;
`include "motor_command_frame_parser_macros.svh"

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       out_valid_q;
  logic       frame_done_q;
  logic       encoder_reset_q;
  held_t      held_out_q;

  logic       out_free;
  logic       commit;
  logic       has_result;
  logic       seq_hit;
  parse_evt_t evt;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign commit     = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign has_result = commit && (evt.done || seq_hit);

  mcfp_frame_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (commit),
    .byte_i (byte_q),
    .evt_o  (evt)
  );

  mcfp_seq_detect u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (commit),
    .byte_i (byte_q),
    .hit_o  (seq_hit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= has_result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (has_result) begin
      frame_done_q    <= evt.done;
      encoder_reset_q <= seq_hit;
      held_out_q      <= evt.held;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign frame_done_o    = frame_done_q;
  assign encoder_reset_o = encoder_reset_q;
  assign speed_a_o       = held_out_q.speed[0];
  assign speed_b_o       = held_out_q.speed[1];
  assign speed_c_o       = held_out_q.speed[2];
  assign speed_d_o       = held_out_q.speed[3];
  assign angle_vel_a_o   = held_out_q.angle_vel[0];
  assign angle_vel_b_o   = held_out_q.angle_vel[1];
  assign angle_vel_c_o   = held_out_q.angle_vel[2];
  assign angle_vel_d_o   = held_out_q.angle_vel[3];
  assign ramp_enable_o   = held_out_q.ramp;

  `MCFP_ASSERT_IMP(a_result_has_event, out_valid_q, frame_done_q || encoder_reset_q)
  `MCFP_ASSERT_IMP(a_stall_only_full, in_stall_o, in_valid_q && out_valid_q && out_stall_i)
  `MCFP_ASSERT_NXT(a_drain_clears, out_valid_q && !out_stall_i && !has_result, !out_valid_q)

endmodule

`default_nettype wire

FILE: verif/motor_command_frame_parser_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for motor_command_frame_parser: a byte driver fed from a queue,
// a result monitor and an in-bench model of the frame parser and "!@!" detector.
// Depends on mcfp_pkg and the parser RTL only.

module motor_command_frame_parser_tb;

  import mcfp_pkg::*;

  typedef enum logic [1:0] {PH_HUNT, PH_BODY, PH_TAIL} parse_phase_e;

  typedef struct {
    logic [7:0] data;
    bit         drain;
    bit         calm;
  } byte_job_t;

  typedef struct packed {
    logic  done;
    logic  enc_rst;
    held_t held;
  } motor_result_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [7:0]       rx_byte_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic             frame_done_o;
  logic             encoder_reset_o;
  sbyte_t           speed_a_o;
  sbyte_t           speed_b_o;
  sbyte_t           speed_c_o;
  sbyte_t           speed_d_o;
  sbyte_t           angle_vel_a_o;
  sbyte_t           angle_vel_b_o;
  sbyte_t           angle_vel_c_o;
  sbyte_t           angle_vel_d_o;
  logic             ramp_enable_o;

  byte_job_t        rx_jobs[$];
  motor_result_t    due_commands[$];

  parse_phase_e     phase = PH_HUNT;
  logic [3:0]       position = '0;
  logic [7:0]       body [DataLen];
  logic [7:0]       recent [3] = '{default: 8'h00};
  logic [1:0]       slot = '0;
  held_t            held = '0;

  bit               byte_taken = 1'b0;
  bit               quiet = 1'b0;
  bit               calm_fill = 1'b0;
  int               send_gap = 0;
  int               recv_gap = 0;
  int               errors = 0;
  int               bytes_taken = 0;
  int               frames_seen = 0;
  int               resets_seen = 0;
  int               results_seen = 0;

  motor_command_frame_parser u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .frame_done_o    (frame_done_o),
    .encoder_reset_o (encoder_reset_o),
    .speed_a_o       (speed_a_o),
    .speed_b_o       (speed_b_o),
    .speed_c_o       (speed_c_o),
    .speed_d_o       (speed_d_o),
    .angle_vel_a_o   (angle_vel_a_o),
    .angle_vel_b_o   (angle_vel_b_o),
    .angle_vel_c_o   (angle_vel_c_o),
    .angle_vel_d_o   (angle_vel_d_o),
    .ramp_enable_o   (ramp_enable_o)
  );

  function automatic bit step_parser(input logic [7:0] b, output motor_result_t res);
    int  s;
    bit  hit;
    bit  done;
    s = (slot > 2) ? 0 : int'(slot);
    recent[s] = b;
    s = (s + 1) % 3;
    slot = s[1:0];
    hit = (recent[s] == TailByte) && (recent[(s + 1) % 3] == AtByte) &&
          (recent[(s + 2) % 3] == TailByte);
    if (hit) begin
      recent = '{default: 8'h00};
      slot = '0;
    end
    done = 1'b0;
    case (phase)
      PH_HUNT: begin
        if (b == HdrByte) begin
          position = 4'd1;
          phase = PH_BODY;
        end
      end
      PH_BODY: begin
        if (position >= 1 && position <= DataLen) begin
          body[position - 1] = b;
          position = position + 4'd1;
          if (position > DataLen) phase = PH_TAIL;
        end else begin
          phase = PH_TAIL;
        end
      end
      PH_TAIL: begin
        if (b == TailByte) begin
          for (int i = 0; i < 4; i++) begin
            held.speed[i] = body[i];
            held.angle_vel[i] = body[5 + i];
          end
          held.ramp = body[4][RampBit];
          done = 1'b1;
        end
        phase = PH_HUNT;
      end
      default: phase = PH_HUNT;
    endcase
    res.done = done;
    res.enc_rst = hit;
    res.held = held;
    return done || hit;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 11))
      0: return HdrByte;
      1: return TailByte;
      2: return AtByte;
      3: return 8'h80;
      4: return 8'h7F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] data, input bit drain);
    byte_job_t job;
    job.data = data;
    job.drain = drain;
    job.calm = calm_fill;
    rx_jobs.push_back(job);
  endtask

  task automatic push_frame(input logic [7:0] tail, input bit with_seq, input bit drain,
                            inout int count);
    push_byte(HdrByte, drain);
    for (int i = 0; i < DataLen; i++) begin
      if (with_seq && i == DataLen - 2) push_byte(TailByte, 1'b0);
      else if (with_seq && i == DataLen - 1) push_byte(AtByte, 1'b0);
      else push_byte(pick_byte(), 1'b0);
    end
    push_byte(tail, 1'b0);
    count += DataLen + 2;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // driver: hold a stalled byte, otherwise advance to the next job or idle
  always @(negedge clk_i) begin : byte_driver
    byte_job_t job;
    logic      nxt_valid;
    logic [7:0] nxt_byte;
    if (rst_ni && (!in_valid_i || byte_taken)) begin
      nxt_valid = 1'b0;
      nxt_byte = rx_byte_i;
      if (send_gap > 0) begin
        send_gap--;
      end else if (rx_jobs.size() > 0) begin
        if (rx_jobs[0].drain && due_commands.size() > 0) begin
          nxt_valid = 1'b0;
        end else if (!rx_jobs[0].calm && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 14);
        end else begin
          job = rx_jobs.pop_front();
          nxt_valid = 1'b1;
          nxt_byte = job.data;
          quiet <= job.calm;
        end
      end
      in_valid_i <= nxt_valid;
      rx_byte_i <= nxt_byte;
    end
  end

  always @(negedge clk_i) begin : result_stall
    if (rst_ni) begin
      if (recv_gap > 0) begin
        recv_gap--;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        recv_gap = $urandom_range(0, 14);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    motor_result_t want;
    motor_result_t made;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (due_commands.size() == 0) begin
          errors++;
          $display("%0t: result with none expected, frame_done %0b encoder_reset %0b",
                   $time, frame_done_o, encoder_reset_o);
        end else begin
          want = due_commands.pop_front();
          if (want.done) frames_seen++;
          if (want.enc_rst) resets_seen++;
          check_field("frame_done", 8'(want.done), 8'(frame_done_o));
          check_field("encoder_reset", 8'(want.enc_rst), 8'(encoder_reset_o));
          check_field("speed_a", want.held.speed[0], speed_a_o);
          check_field("speed_b", want.held.speed[1], speed_b_o);
          check_field("speed_c", want.held.speed[2], speed_c_o);
          check_field("speed_d", want.held.speed[3], speed_d_o);
          check_field("angle_vel_a", want.held.angle_vel[0], angle_vel_a_o);
          check_field("angle_vel_b", want.held.angle_vel[1], angle_vel_b_o);
          check_field("angle_vel_c", want.held.angle_vel[2], angle_vel_c_o);
          check_field("angle_vel_d", want.held.angle_vel[3], angle_vel_d_o);
          check_field("ramp_enable", 8'(want.held.ramp), 8'(ramp_enable_o));
        end
      end
      byte_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        bytes_taken++;
        if (step_parser(rx_byte_i, made)) due_commands.push_back(made);
      end
    end
  end

  initial begin : stimulus
    logic [7:0] directed [27];
    int         count;
    int         sel;
    int         n;
    bit         drain;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    rx_byte_i = 8'h00;
    out_stall_i = 1'b0;

    // valid frame whose tail also closes "!@!", bad tail on '#', then "!@!@!"
    directed = '{HdrByte, 8'h80, 8'h7F, HdrByte, 8'hFF, 8'h01, 8'h00, 8'hFF, TailByte,
                 AtByte, TailByte,
                 HdrByte, 8'h00, 8'h55, 8'hAA, 8'hFE, 8'h01, 8'h7F, 8'h80, 8'h33, 8'hCC,
                 HdrByte,
                 TailByte, AtByte, TailByte, AtByte, TailByte};
    foreach (directed[i]) push_byte(directed[i], 1'b0);

    count = 0;
    drain = 1'b1;
    while (count < 600) begin
      if (count > 520) calm_fill = 1'b1;
      sel = $urandom_range(0, 19);
      if (sel < 12) begin
        push_frame(TailByte, $urandom_range(0, 4) == 0, drain, count);
      end else if (sel < 14) begin
        push_frame(($urandom_range(0, 1) == 0) ? HdrByte : pick_byte(), 1'b0, drain, count);
      end else if (sel < 16) begin
        push_byte(TailByte, drain);
        push_byte(AtByte, 1'b0);
        push_byte(TailByte, 1'b0);
        count += 3;
        if ($urandom_range(0, 1) == 0) begin
          push_byte(AtByte, 1'b0);
          push_byte(TailByte, 1'b0);
          count += 2;
        end
      end else if (sel < 18) begin
        push_byte(HdrByte, drain);
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) push_byte(pick_byte(), 1'b0);
        count += n + 1;
      end else begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) push_byte(pick_byte(), drain && i == 0);
        count += n;
      end
      drain = ($urandom_range(0, 24) == 0);
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (rx_jobs.size() != 0 || in_valid_i || due_commands.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d bytes; checked %0d results: %0d parsed frames, %0d encoder resets",
             bytes_taken, results_seen, frames_seen, resets_seen);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/mcfp_pkg.sv
rtl/mcfp_frame_fsm.sv
rtl/mcfp_seq_detect.sv
rtl/motor_command_frame_parser.sv
verif/motor_command_frame_parser_tb.sv
